### sv/asds_pkg.sv
package asds_pkg;

    // Pool geometry
    localparam int POOL_DEPTH = 64;
    localparam int CNT_W      = $clog2(POOL_DEPTH + 1);

    // Field widths
    localparam int LOC_W  = 18;
    localparam int PID_W  = 16;
    localparam int KEY_W  = LOC_W + PID_W;
    localparam int TIME_W = 32;
    localparam int ST_W   = 8;

    // Configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic [ST_W-1:0] SERVICE_TIME_RESET = ST_W'(5);

    // Register indexes
    typedef enum logic [0:0] {
        REG_SERVICE_TIME = 1'b0
    } t_reg_idx;

    // Operations
    typedef enum logic [0:0] {
        OP_ENQUEUE = 1'b0,
        OP_SWEEP   = 1'b1
    } t_opcode;

    // Result status
    typedef enum logic [0:0] {
        ST_SERVED   = 1'b0,
        ST_REJECTED = 1'b1
    } t_status;

    // One stored request: key = {location, process id}
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
    } t_entry;

    // Row control, broadcast to every cell
    typedef struct packed {
        logic ins;
        logic pop;
        logic asc;
    } t_row_ctrl;

endpackage

### sv/asds_cell.sv
// One slot of the sorted request row. Keeps the row in service order:
// on insert it shifts toward the tail or takes the new key, on pop it
// takes its tail-side neighbor.
module asds_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  asds_pkg::t_row_ctrl         i_ctrl,
    input  logic [asds_pkg::KEY_W-1:0]  i_new_key,
    input  asds_pkg::t_entry            i_prev_ent,
    input  logic                        i_prev_take,
    input  asds_pkg::t_entry            i_next_ent,
    output asds_pkg::t_entry            o_ent,
    output logic                        o_take
);

    asds_pkg::t_entry r_ent;
    asds_pkg::t_entry n_ent;
    logic             w_first;

    // new key is served before the stored one
    always_comb begin
        w_first = i_ctrl.asc ? (i_new_key < r_ent.key) : (i_new_key > r_ent.key);
        o_take  = !r_ent.valid || w_first;
    end

    // next slot content
    always_comb begin
        n_ent = r_ent;
        if (i_ctrl.ins) begin
            if (i_prev_take) begin
                n_ent = i_prev_ent;
            end else if (o_take) begin
                n_ent.valid = 1'b1;
                n_ent.key   = i_new_key;
            end
        end else if (i_ctrl.pop) begin
            n_ent = i_next_ent;
        end
    end

    // valid bit is reset, key is not
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent.valid <= 1'b0;
        end else begin
            r_ent.valid <= n_ent.valid;
        end
        r_ent.key <= n_ent.key;
    end

    assign o_ent = r_ent;

endmodule

### sv/asds_cell_row.sv
// Row of POOL_DEPTH cells; cell 0 always holds the next request to serve.
module asds_cell_row (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  asds_pkg::t_row_ctrl         i_ctrl,
    input  logic [asds_pkg::KEY_W-1:0]  i_new_key,
    output asds_pkg::t_entry            o_head
);

    asds_pkg::t_entry w_ent  [asds_pkg::POOL_DEPTH];
    logic             w_take [asds_pkg::POOL_DEPTH];

    for (genvar g = 0; g < asds_pkg::POOL_DEPTH; g++) begin : g_cell
        asds_pkg::t_entry w_prev_ent;
        asds_pkg::t_entry w_next_ent;
        logic             w_prev_take;

        // neighbor links, ends tied off
        if (g == 0) begin : g_head
            assign w_prev_ent  = '0;
            assign w_prev_take = 1'b0;
        end else begin : g_mid
            assign w_prev_ent  = w_ent[g-1];
            assign w_prev_take = w_take[g-1];
        end
        if (g == asds_pkg::POOL_DEPTH - 1) begin : g_tail
            assign w_next_ent = '0;
        end else begin : g_body
            assign w_next_ent = w_ent[g+1];
        end

        asds_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (i_ctrl),
            .i_new_key   (i_new_key),
            .i_prev_ent  (w_prev_ent),
            .i_prev_take (w_prev_take),
            .i_next_ent  (w_next_ent),
            .o_ent       (w_ent[g]),
            .o_take      (w_take[g])
        );
    end

    assign o_head = w_ent[0];

endmodule

### sv/alternating_sweep_disk_scheduler.sv
// Enqueue: busy stays low; a rejected enqueue (pool full) gives its word on the cycle
// after acceptance. Sweep of N requests: busy until the last one is served, one served
// word per cycle, the first registered after the state turns to sweep, last word marked;
// the cell row pops its head once per cycle. An empty sweep gives no word.
// Synchronous active-low reset empties the pool, clears the clock, sets the first
// sweep descending and service_time to 5. Results cannot be stalled by the receiver.
module alternating_sweep_disk_scheduler (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // command channel
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_opcode,
    input  logic [asds_pkg::LOC_W-1:0]     i_location,
    input  logic [asds_pkg::PID_W-1:0]     i_process_id,
    // result channel
    output logic                           o_valid,
    output logic                           o_status,
    output logic [asds_pkg::TIME_W-1:0]    o_completion_time,
    output logic [asds_pkg::PID_W-1:0]     o_served_process,
    output logic [asds_pkg::LOC_W-1:0]     o_served_location,
    output logic                           o_last,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [asds_pkg::ADDR_W-1:0]    paddr,
    input  logic [asds_pkg::DATA_W-1:0]    pwdata,
    output logic [asds_pkg::DATA_W-1:0]    prdata,
    output logic                           pready
);

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_SWEEP = 2'b10
    } t_state;

    t_state                          r_state, n_state;
    logic [asds_pkg::CNT_W-1:0]      r_count, n_count;
    logic                            r_asc, n_asc;
    logic [asds_pkg::TIME_W-1:0]     r_clock, n_clock;
    logic [asds_pkg::ST_W-1:0]       r_service_time;

    logic                            r_valid, n_valid;
    logic                            r_status, n_status;
    logic [asds_pkg::TIME_W-1:0]     r_time, n_time;
    logic [asds_pkg::PID_W-1:0]      r_pid, n_pid;
    logic [asds_pkg::LOC_W-1:0]      r_loc, n_loc;
    logic                            r_last, n_last;

    logic                            w_accept;
    logic                            w_full;
    logic                            w_wr;
    asds_pkg::t_row_ctrl             w_ctrl;
    asds_pkg::t_entry                w_head;

    // config register access
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite
                    && (paddr[asds_pkg::ADDR_W-1:2] == asds_pkg::REG_SERVICE_TIME);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_service_time <= asds_pkg::SERVICE_TIME_RESET;
        end else if (w_wr) begin
            r_service_time <= pwdata[asds_pkg::ST_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[asds_pkg::ADDR_W-1:2] == asds_pkg::REG_SERVICE_TIME) begin
            prdata = asds_pkg::DATA_W'(r_service_time);
        end
    end

    // command handling
    assign busy     = (r_state == S_SWEEP);
    assign w_accept = start && !busy;
    assign w_full   = (r_count == asds_pkg::CNT_W'(asds_pkg::POOL_DEPTH));

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_asc    = r_asc;
        n_clock  = r_clock;
        n_valid  = 1'b0;
        n_status = asds_pkg::ST_SERVED;
        n_time   = r_time;
        n_pid    = r_pid;
        n_loc    = r_loc;
        n_last   = 1'b0;
        w_ctrl.ins = 1'b0;
        w_ctrl.pop = 1'b0;
        w_ctrl.asc = r_asc;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_opcode == asds_pkg::OP_ENQUEUE) begin
                        if (w_full) begin
                            n_valid  = 1'b1;
                            n_status = asds_pkg::ST_REJECTED;
                            n_time   = '0;
                            n_pid    = i_process_id;
                            n_loc    = i_location;
                            n_last   = 1'b1;
                        end else begin
                            w_ctrl.ins = 1'b1;
                            n_count    = r_count + 1'b1;
                        end
                    end else if (r_count == '0) begin
                        n_asc = !r_asc;
                    end else begin
                        n_state = S_SWEEP;
                    end
                end
            end
            S_SWEEP: begin
                // serve the head cell, shift the row forward
                w_ctrl.pop = 1'b1;
                n_clock    = r_clock + asds_pkg::TIME_W'(r_service_time);
                n_count    = r_count - 1'b1;
                n_valid    = 1'b1;
                n_status   = asds_pkg::ST_SERVED;
                n_time     = n_clock;
                n_pid      = w_head.key[asds_pkg::PID_W-1:0];
                n_loc      = w_head.key[asds_pkg::KEY_W-1:asds_pkg::PID_W];
                if (r_count == asds_pkg::CNT_W'(1)) begin
                    n_last  = 1'b1;
                    n_asc   = !r_asc;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_asc   <= 1'b0;
            r_clock <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_asc   <= n_asc;
            r_clock <= n_clock;
            r_valid <= n_valid;
        end
    end

    // result word payload
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_time   <= n_time;
        r_pid    <= n_pid;
        r_loc    <= n_loc;
        r_last   <= n_last;
    end

    asds_cell_row u_row (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (w_ctrl),
        .i_new_key ({i_location, i_process_id}),
        .o_head    (w_head)
    );

    assign o_valid           = r_valid;
    assign o_status          = r_status;
    assign o_completion_time = r_time;
    assign o_served_process  = r_pid;
    assign o_served_location = r_loc;
    assign o_last            = r_last;

endmodule

### test/tb_alternating_sweep_disk_scheduler.sv
`timescale 1ns / 100ps

module tb_alternating_sweep_disk_scheduler;

    import asds_pkg::*;

    localparam int N_DIR        = 19;
    localparam int TARGET_WORDS = 380;
    localparam int PHASE_WORDS  = 45;
    localparam int SETTLE_CYC   = 8;
    localparam int MAX_PRINT    = 20;
    localparam logic [LOC_W-1:0]  LOC_MAX = '1;
    localparam logic [PID_W-1:0]  PID_MAX = '1;
    localparam logic [ADDR_W-1:0] ADDR_SERVICE_TIME = ADDR_W'(4 * int'(REG_SERVICE_TIME));

    // one result word
    typedef struct packed {
        t_status           status;
        logic [TIME_W-1:0] ctime;
        logic [PID_W-1:0]  pid;
        logic [LOC_W-1:0]  loc;
        logic              last;
    } t_completion;

    // pooled request; packed order makes the struct itself the sort key
    typedef struct packed {
        logic [LOC_W-1:0] loc;
        logic [PID_W-1:0] pid;
    } t_req;

    // directed stimulus row; n_known < 0 means the predictor supplies the results
    typedef struct {
        t_opcode          op;
        logic [LOC_W-1:0] loc;
        logic [PID_W-1:0] pid;
        int               n_known;
        t_completion      k0;
        t_completion      k1;
    } t_stim_row;

    // DUT signals
    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic              i_opcode = 1'b0;
    logic [LOC_W-1:0]  i_location = '0;
    logic [PID_W-1:0]  i_process_id = '0;
    logic              o_valid;
    logic              o_status;
    logic [TIME_W-1:0] o_completion_time;
    logic [PID_W-1:0]  o_served_process;
    logic [LOC_W-1:0]  o_served_location;
    logic              o_last;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // scheduler shadow state
    t_req              pool_q[$];
    bit                sweep_up;
    logic [TIME_W-1:0] disk_clock;
    logic [ST_W-1:0]   svc_ticks;
    t_completion       sched_out[$];
    t_completion       pending_done[$];

    // run statistics
    int unsigned n_words;
    int unsigned n_checked;
    int unsigned n_rejects;
    int unsigned n_errors;
    int unsigned n_sweeps;
    int unsigned n_settings;
    int          burst_left;

    t_completion want;
    t_completion got;
    string       diff;

    t_stim_row dir_rows [N_DIR] = '{
        // empty first sweep: nothing out, direction flips to ascending
        '{OP_SWEEP,   18'h12345, 16'hbeef, 0, '0, '0},
        '{OP_ENQUEUE, 18'h00000, 16'h0000, 0, '0, '0},
        '{OP_ENQUEUE, 18'h3ffff, 16'hffff, 0, '0, '0},
        '{OP_SWEEP,   18'h00000, 16'h0000, 2,
          '{ST_SERVED, 32'd5,  16'h0000, 18'h00000, 1'b0},
          '{ST_SERVED, 32'd10, 16'hffff, 18'h3ffff, 1'b1}},
        // location ties broken by process id, one duplicate key
        '{OP_ENQUEUE, 18'h00100, 16'h0007, 0, '0, '0},
        '{OP_ENQUEUE, 18'h00100, 16'h0003, 0, '0, '0},
        '{OP_ENQUEUE, 18'h00100, 16'h0007, 0, '0, '0},
        '{OP_ENQUEUE, 18'h2aaaa, 16'h5555, 0, '0, '0},
        '{OP_ENQUEUE, 18'h15555, 16'haaaa, 0, '0, '0},
        '{OP_ENQUEUE, 18'h00001, 16'hffff, 0, '0, '0},
        '{OP_SWEEP,   18'h3ffff, 16'hffff, -1, '0, '0},
        '{OP_SWEEP,   18'h2aaaa, 16'h5555, 0, '0, '0},
        '{OP_ENQUEUE, 18'h3ffff, 16'h0000, 0, '0, '0},
        '{OP_ENQUEUE, 18'h00000, 16'hffff, 0, '0, '0},
        '{OP_ENQUEUE, 18'h20000, 16'h8000, 0, '0, '0},
        '{OP_SWEEP,   18'h15555, 16'haaaa, -1, '0, '0},
        '{OP_ENQUEUE, 18'h0ffff, 16'h1234, 0, '0, '0},
        '{OP_ENQUEUE, 18'h0ffff, 16'h1233, 0, '0, '0},
        '{OP_SWEEP,   18'h00000, 16'h0000, -1, '0, '0}
    };

    alternating_sweep_disk_scheduler u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_opcode          (i_opcode),
        .i_location        (i_location),
        .i_process_id      (i_process_id),
        .o_valid           (o_valid),
        .o_status          (o_status),
        .o_completion_time (o_completion_time),
        .o_served_process  (o_served_process),
        .o_served_location (o_served_location),
        .o_last            (o_last),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        n_errors++;
        if (n_errors <= MAX_PRINT)
            $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    // shadow scheduler: fills sched_out with the words one command causes
    task automatic sched_predict(input t_opcode op, input logic [LOC_W-1:0] loc,
                                 input logic [PID_W-1:0] pid);
        int          best;
        t_completion r;
        sched_out.delete();
        if (op == OP_ENQUEUE) begin
            if (pool_q.size() >= POOL_DEPTH) begin
                r = '{ST_REJECTED, '0, pid, loc, 1'b1};
                sched_out.push_back(r);
            end else begin
                pool_q.push_back('{loc, pid});
            end
        end else begin
            while (pool_q.size() > 0) begin
                best = 0;
                for (int i = 1; i < pool_q.size(); i++)
                    if (sweep_up ? (pool_q[i] < pool_q[best]) : (pool_q[i] > pool_q[best]))
                        best = i;
                disk_clock = disk_clock + TIME_W'(svc_ticks);
                r = '{ST_SERVED, disk_clock, pool_q[best].pid, pool_q[best].loc, 1'b0};
                sched_out.push_back(r);
                pool_q.delete(best);
            end
            if (sched_out.size() > 0)
                sched_out[sched_out.size() - 1].last = 1'b1;
            sweep_up = !sweep_up;
        end
    endtask

    // present one command word and hold it until accepted
    task automatic drive_word(input t_opcode op, input logic [LOC_W-1:0] loc,
                              input logic [PID_W-1:0] pid);
        @(negedge i_clk);
        start        <= 1'b1;
        i_opcode     <= op;
        i_location   <= loc;
        i_process_id <= pid;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        n_words++;
        if (op == OP_SWEEP) n_sweeps++;
        sched_predict(op, loc, pid);
    endtask

    task automatic issue(input t_opcode op, input logic [LOC_W-1:0] loc,
                         input logic [PID_W-1:0] pid);
        drive_word(op, loc, pid);
        foreach (sched_out[i]) pending_done.push_back(sched_out[i]);
    endtask

    // sender pacing: bursts of random length separated by random gaps
    task automatic pace(input bit steady);
        if (!steady) begin
            if (burst_left <= 0) begin
                repeat ($urandom_range(1, 6)) @(negedge i_clk) start <= 1'b0;
                burst_left = $urandom_range(1, 10);
            end
            burst_left--;
        end
    endtask

    // stop sending and wait for every outstanding word, plus settle time
    task automatic drain();
        @(negedge i_clk) start <= 1'b0;
        while (pending_done.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [ST_W-1:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_SERVICE_TIME;
        // upper data bits are don't-care for an 8-bit register
        pwdata  <= {(DATA_W - ST_W)'($urandom()), val};
        @(negedge i_clk) penable <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (pready) break;
        end
        svc_ticks = val;
        n_settings++;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic cfg_check();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_SERVICE_TIME;
        @(negedge i_clk) penable <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (pready) break;
        end
        if (prdata[ST_W-1:0] !== svc_ticks)
            report_mismatch($sformatf("service_time read %0h, want %0h",
                                      prdata[ST_W-1:0], svc_ticks));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // field values biased toward ties and the ends of the range
    function automatic logic [LOC_W-1:0] pick_loc();
        case ($urandom_range(0, 3))
            0:       return LOC_W'($urandom_range(0, 3));
            1:       return LOC_MAX - LOC_W'($urandom_range(0, 3));
            default: return LOC_W'($urandom());
        endcase
    endfunction

    function automatic logic [PID_W-1:0] pick_pid();
        case ($urandom_range(0, 3))
            0:       return PID_W'($urandom_range(0, 2));
            1:       return PID_MAX - PID_W'($urandom_range(0, 2));
            default: return PID_W'($urandom());
        endcase
    endfunction

    // random phase: mostly enqueue runs closed by a sweep, some noise
    task automatic run_phase(input int budget, input bit steady, input bit fill_pool);
        int sent;
        int runlen;
        int roll;
        sent = 0;
        while (sent < budget) begin
            roll = $urandom_range(0, 99);
            if (fill_pool && sent == 0)
                runlen = POOL_DEPTH - pool_q.size() + $urandom_range(1, 3);
            else if (roll < 70)
                runlen = $urandom_range(0, 10);
            else if (roll < 85)
                runlen = $urandom_range(11, 40);
            else
                runlen = -1;
            if (runlen < 0) begin
                pace(steady);
                issue($urandom_range(0, 1) ? OP_SWEEP : OP_ENQUEUE, pick_loc(), pick_pid());
                sent++;
            end else begin
                for (int i = 0; i < runlen; i++) begin
                    pace(steady);
                    issue(OP_ENQUEUE, pick_loc(), pick_pid());
                    sent++;
                end
                pace(steady);
                issue(OP_SWEEP, pick_loc(), pick_pid());
                sent++;
            end
            // occasionally hold off until the block has emptied out
            if ($urandom_range(0, 19) == 0)
                drain();
        end
    endtask

    // result checker: every strobed word against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_done.size() == 0) begin
                report_mismatch("result word with nothing expected");
            end else begin
                want = pending_done.pop_front();
                got  = '{t_status'(o_status), o_completion_time, o_served_process,
                         o_served_location, o_last};
                diff = "";
                if (got.status !== want.status)
                    diff = {diff, $sformatf(" status %0h/%0h", got.status, want.status)};
                if (got.ctime !== want.ctime)
                    diff = {diff, $sformatf(" time %0h/%0h", got.ctime, want.ctime)};
                if (got.pid !== want.pid)
                    diff = {diff, $sformatf(" pid %0h/%0h", got.pid, want.pid)};
                if (got.loc !== want.loc)
                    diff = {diff, $sformatf(" loc %0h/%0h", got.loc, want.loc)};
                if (got.last !== want.last)
                    diff = {diff, $sformatf(" last %0h/%0h", got.last, want.last)};
                if (diff != "")
                    report_mismatch({"word got/want:", diff});
                n_checked++;
                if (want.status == ST_REJECTED) n_rejects++;
            end
        end
    end

    // main sequence
    initial begin
        sweep_up   = 1'b0;
        disk_clock = '0;
        svc_ticks  = SERVICE_TIME_RESET;
        burst_left = 0;
        n_words    = 0;
        n_checked  = 0;
        n_rejects  = 0;
        n_errors   = 0;
        n_sweeps   = 0;
        n_settings = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // reset value of the register, then the directed table
        cfg_check();
        for (int i = 0; i < N_DIR; i++) begin
            pace(1'b0);
            drive_word(dir_rows[i].op, dir_rows[i].loc, dir_rows[i].pid);
            if (dir_rows[i].n_known < 0) begin
                foreach (sched_out[j]) pending_done.push_back(sched_out[j]);
            end else begin
                if (dir_rows[i].n_known > 0) pending_done.push_back(dir_rows[i].k0);
                if (dir_rows[i].n_known > 1) pending_done.push_back(dir_rows[i].k1);
            end
        end
        drain();

        // random phases, each under its own service time
        for (int ph = 0; n_words < TARGET_WORDS; ph++) begin
            case (ph)
                0:       cfg_write(ST_W'(255));
                1:       cfg_write(ST_W'(0));
                2:       cfg_write(ST_W'(1));
                default: cfg_write(ST_W'($urandom_range(1, 255)));
            endcase
            cfg_check();
            run_phase(PHASE_WORDS, (ph % 4) == 3, (ph % 3) == 2);
            drain();
        end

        $display("Sent %0d command words (%0d sweeps) over %0d service-time settings.",
                 n_words, n_sweeps, n_settings);
        $display("Checked %0d result words, %0d of them pool-full rejects.",
                 n_checked, n_rejects);
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("Timeout: %0d result words still outstanding", pending_done.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
